// ----- sv/awep_pkg.sv -----
`default_nettype none
package awep_pkg;

    localparam int WEIGHT_W        = 32;
    localparam int TOTAL_W         = 40;
    localparam int FRAC_IN_W       = 16;
    localparam int INDEX_OUT_W     = 8;
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF   = 16;

    typedef enum logic
    {
        KIND_APPEND = 1'b0,
        KIND_PICK   = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        kind_t                  kind;
        logic [WEIGHT_W-1:0]    entry_weight;
        logic [FRAC_IN_W-1:0]   random_fraction;
    } in_t;

    typedef struct packed
    {
        logic [INDEX_OUT_W-1:0] chosen_index;
        status_t                status;
    } out_t;

    typedef struct packed
    {
        logic capture;
        logic append;
        logic trivial;
        logic scale;
        logic walk;
    } cmd_t;

    typedef struct packed
    {
        logic cnt_lt2;
        logic walk_done;
    } stat_t;

endpackage
`default_nettype wire

// ----- sv/area_weighted_entry_picker.sv -----
// append and trivial picks (empty table or one entry): the APPEND or TRIVIAL state sets the
// registered result strobe; other picks: the SCALE multiply state, then one table read per entry
// walked in WALK, until the running sum exceeds the selector or the last entry is read
// busy stays high until the result cycle, so the next transaction can start then
// reset clears entry count, running total and the controller; table contents are not cleared
// the receiver cannot stall: done is a one-cycle strobe from an output register
`default_nettype none
module area_weighted_entry_picker #(
    parameter int MAX_ENTRIES   = awep_pkg::MAX_ENTRIES_DEF,
    parameter int FRACTION_BITS = awep_pkg::FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire awep_pkg::in_t item,
    output logic               done,
    output awep_pkg::out_t     result
);
    import awep_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    awep_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    awep_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule
`default_nettype wire

// ----- sv/awep_ram.sv -----
`default_nettype none
module awep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/awep_ctrl.sv -----
`default_nettype none
module awep_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire awep_pkg::kind_t kind,
    input  wire awep_pkg::stat_t stat,
    output logic                busy,
    output awep_pkg::cmd_t      cmd
);
    import awep_pkg::*;

    typedef enum logic [4:0]
    {
        ST_IDLE    = 5'b00001,
        ST_APPEND  = 5'b00010,
        ST_TRIVIAL = 5'b00100,
        ST_SCALE   = 5'b01000,
        ST_WALK    = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_APPEND)
                    begin
                        state_next = ST_APPEND;
                    end
                    else if (stat.cnt_lt2)
                    begin
                        state_next = ST_TRIVIAL;
                    end
                    else
                    begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_APPEND:  state_next = ST_IDLE;
            ST_TRIVIAL: state_next = ST_IDLE;
            ST_SCALE:   state_next = ST_WALK;
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cmd.capture = (state_reg == ST_IDLE) && start;
    assign cmd.append  = (state_reg == ST_APPEND);
    assign cmd.trivial = (state_reg == ST_TRIVIAL);
    assign cmd.scale   = (state_reg == ST_SCALE);
    assign cmd.walk    = (state_reg == ST_WALK);

endmodule
`default_nettype wire

// ----- sv/awep_datapath.sv -----
`default_nettype none
module awep_datapath #(
    parameter int MAX_ENTRIES   = 256,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire awep_pkg::in_t  item,
    input  wire awep_pkg::cmd_t cmd,
    output awep_pkg::stat_t     stat,
    output awep_pkg::out_t      result,
    output logic                done
);
    import awep_pkg::*;

    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int FW   = (FRACTION_BITS < FRAC_IN_W) ? FRACTION_BITS : FRAC_IN_W;
    localparam int PW   = TOTAL_W + FW;
    localparam int AW   = WEIGHT_W + IW;
    localparam int CMPW = (AW > TOTAL_W) ? AW : TOTAL_W;
    localparam int XW   = (IW > INDEX_OUT_W) ? IW : INDEX_OUT_W;

    logic [CW-1:0]       count_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                done_reg;
    out_t                res_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [FW-1:0]       frac_reg;
    logic [TOTAL_W-1:0]  selector_reg;
    logic [AW-1:0]       accum_reg;
    logic [IW-1:0]       data_idx_reg;

    logic [CW-1:0]       count_next;
    logic [TOTAL_W-1:0]  total_next;
    logic                done_next;
    out_t                res_next;

    logic                full;
    logic [TOTAL_W:0]    total_sum;
    logic [PW-1:0]       product;
    logic [TOTAL_W-1:0]  selector;
    logic [AW-1:0]       accum_next;
    logic                hit;
    logic                last;
    logic                mem_we;
    logic                mem_re;
    logic [IW-1:0]       mem_raddr;
    logic [WEIGHT_W-1:0] mem_rdata;
    logic [XW-1:0]       count_wide;
    logic [XW-1:0]       data_idx_wide;

    awep_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (weight_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign full       = (count_reg == CW'(MAX_ENTRIES));
    assign total_sum  = {1'b0, total_reg} + (TOTAL_W + 1)'(weight_reg);
    assign product    = PW'(total_reg) * PW'(frac_reg);
    assign selector   = TOTAL_W'(product >> FRACTION_BITS);
    assign accum_next = accum_reg + AW'(mem_rdata);
    assign hit        = CMPW'(selector_reg) < CMPW'(accum_next);
    assign last       = (CW'(data_idx_reg) == (count_reg - CW'(1)));

    assign stat.cnt_lt2   = (count_reg < CW'(2));
    assign stat.walk_done = hit || last;

    assign mem_we    = cmd.append && !full;
    assign mem_re    = cmd.scale || (cmd.walk && !stat.walk_done);
    assign mem_raddr = cmd.scale ? '0 : (data_idx_reg + IW'(1));

    assign count_wide    = XW'(count_reg[IW-1:0]);
    assign data_idx_wide = XW'(data_idx_reg);

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        if (cmd.append)
        begin
            done_next = 1'b1;
            if (full)
            begin
                res_next.chosen_index = '0;
                res_next.status       = STATUS_FULL;
            end
            else
            begin
                count_next            = count_reg + CW'(1);
                total_next            = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                res_next.chosen_index = count_wide[INDEX_OUT_W-1:0];
                res_next.status       = STATUS_OK;
            end
        end
        else if (cmd.trivial)
        begin
            done_next             = 1'b1;
            res_next.chosen_index = '0;
            res_next.status       = (count_reg == '0) ? STATUS_EMPTY : STATUS_OK;
        end
        else if (cmd.walk && stat.walk_done)
        begin
            done_next             = 1'b1;
            res_next.chosen_index = data_idx_wide[INDEX_OUT_W-1:0];
            res_next.status       = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.capture)
        begin
            weight_reg <= item.entry_weight;
            frac_reg   <= item.random_fraction[FW-1:0];
        end
        if (cmd.scale)
        begin
            selector_reg <= selector;
            accum_reg    <= '0;
            data_idx_reg <= '0;
        end
        else if (cmd.walk)
        begin
            accum_reg    <= accum_next;
            data_idx_reg <= data_idx_reg + IW'(1);
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire
